/* hw/rtl/chacha20_block_function_unit_defines.svh */
// assertion macros shared by the chacha20 block function rtl
// expects clk and rst to be in scope where a macro is used
`ifndef CHACHA20_BLOCK_FUNCTION_UNIT_DEFINES_SVH
`define CHACHA20_BLOCK_FUNCTION_UNIT_DEFINES_SVH

// trigger holds now, check holds on the next clock
`define CC20_ASSERT_NXT(label, trig, chk, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (chk)) \
    else $error(msg);

// trigger and check hold on the same clock
`define CC20_ASSERT_IMP(label, trig, chk, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (chk)) \
    else $error(msg);

`endif

/* hw/rtl/cc20_pkg.sv */
`timescale 1ns / 1ps
// package for the chacha20 block function unit: microcode types, step
// addresses and the microcode rom; no dependencies
package cc20_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 4;
  localparam int STEP_W = 4;

  localparam logic [CNT_W-1:0] LAST_CNT = 4'd15;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_COPY,
    OP_STEP_AD,
    OP_STEP_CB,
    OP_DIAG,
    OP_UNDIAG,
    OP_EMIT
  } op_t;

  // sequencing conditions
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_LOAD,
    COND_LOOP,
    COND_WAIT_EMIT,
    COND_JUMP
  } cond_t;

  typedef struct packed {
    op_t               op;
    logic              rot_hi;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // control from sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic rot_hi;
    logic load_en;
    logic emit_en;
    logic last;
  } ctrl_t;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_LOAD      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COPY      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COL_A16   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_COL_C12   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_COL_A8    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_COL_C7    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DIAG      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIA_A16   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DIA_C12   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DIA_A8    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DIA_C7    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_ROUND_END = 4'd11;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd12;

  // microcode rom
  function automatic ucode_t ucode(input logic [STEP_W-1:0] addr);
    ucode_t cw;
    cw.op     = OP_NOP;
    cw.rot_hi = 1'b0;
    cw.cond   = COND_NEXT;
    cw.target = STEP_LOAD;
    case (addr)
      STEP_LOAD: begin
        cw.op   = OP_LOAD;
        cw.cond = COND_WAIT_LOAD;
      end
      STEP_COPY: cw.op = OP_COPY;
      STEP_COL_A16, STEP_DIA_A16: cw.op = OP_STEP_AD;
      STEP_COL_C12, STEP_DIA_C12: cw.op = OP_STEP_CB;
      STEP_COL_A8, STEP_DIA_A8: begin
        cw.op     = OP_STEP_AD;
        cw.rot_hi = 1'b1;
      end
      STEP_COL_C7, STEP_DIA_C7: begin
        cw.op     = OP_STEP_CB;
        cw.rot_hi = 1'b1;
      end
      STEP_DIAG: cw.op = OP_DIAG;
      STEP_ROUND_END: begin
        cw.op     = OP_UNDIAG;
        cw.cond   = COND_LOOP;
        cw.target = STEP_COL_A16;
      end
      STEP_EMIT: begin
        cw.op     = OP_EMIT;
        cw.cond   = COND_WAIT_EMIT;
        cw.target = STEP_LOAD;
      end
      default: begin
        cw.op     = OP_NOP;
        cw.cond   = COND_JUMP;
        cw.target = STEP_LOAD;
      end
    endcase
    return cw;
  endfunction

endpackage

/* hw/rtl/cc20_sequencer.sv */
`timescale 1ns / 1ps
// microcode sequencer: step counter, rom lookup, load/round/emit counters
// depends on cc20_pkg and chacha20_block_function_unit_defines.svh
`include "chacha20_block_function_unit_defines.svh"

module cc20_sequencer #(
  parameter int ROUND_PAIRS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_valid,
  input  logic            out_stall,
  output cc20_pkg::ctrl_t ctrl
);

  localparam int RND_W = (ROUND_PAIRS > 1) ? $clog2(ROUND_PAIRS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_PAIRS - 1);

  logic [cc20_pkg::STEP_W-1:0] step;
  logic [cc20_pkg::STEP_W-1:0] step_next;
  logic [cc20_pkg::CNT_W-1:0]  load_cnt;
  logic [cc20_pkg::CNT_W-1:0]  emit_cnt;
  logic [RND_W-1:0]            round_cnt;
  cc20_pkg::ucode_t            cw;
  logic                        load_en;
  logic                        emit_en;
  logic                        rounds_left;

  // rom lookup and handshake enables
  always_comb begin
    cw          = cc20_pkg::ucode(step);
    load_en     = (cw.op == cc20_pkg::OP_LOAD) && in_valid;
    emit_en     = (cw.op == cc20_pkg::OP_EMIT) && (!out_valid || !out_stall);
    rounds_left = (round_cnt != RND_LAST);
  end

  // next step
  always_comb begin
    step_next = step;
    case (cw.cond)
      cc20_pkg::COND_NEXT: step_next = step + cc20_pkg::STEP_W'(1);
      cc20_pkg::COND_WAIT_LOAD: begin
        if (load_en && (load_cnt == cc20_pkg::LAST_CNT)) begin
          step_next = step + cc20_pkg::STEP_W'(1);
        end
      end
      cc20_pkg::COND_LOOP: begin
        step_next = rounds_left ? cw.target : step + cc20_pkg::STEP_W'(1);
      end
      cc20_pkg::COND_WAIT_EMIT: begin
        if (emit_en && (emit_cnt == cc20_pkg::LAST_CNT)) begin
          step_next = cw.target;
        end
      end
      cc20_pkg::COND_JUMP: step_next = cw.target;
      default: step_next = cc20_pkg::STEP_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall     = (cw.op != cc20_pkg::OP_LOAD);
    ctrl.op      = cw.op;
    ctrl.rot_hi  = cw.rot_hi;
    ctrl.load_en = load_en;
    ctrl.emit_en = emit_en;
    ctrl.last    = (emit_cnt == cc20_pkg::LAST_CNT);
  end

  // step counter and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= cc20_pkg::STEP_LOAD;
      load_cnt  <= '0;
      emit_cnt  <= '0;
      round_cnt <= '0;
    end else begin
      step <= step_next;
      if (load_en) begin
        load_cnt <= load_cnt + cc20_pkg::CNT_W'(1);
      end
      if (emit_en) begin
        emit_cnt <= emit_cnt + cc20_pkg::CNT_W'(1);
      end
      if (cw.op == cc20_pkg::OP_COPY) begin
        round_cnt <= '0;
      end else if ((cw.cond == cc20_pkg::COND_LOOP) && rounds_left) begin
        round_cnt <= round_cnt + RND_W'(1);
      end
    end
  end

  // checks
  `CC20_ASSERT_NXT(a_load_to_copy, load_en && (load_cnt == cc20_pkg::LAST_CNT),
                   step == cc20_pkg::STEP_COPY, "copy does not follow sixteenth word")
  `CC20_ASSERT_NXT(a_emit_to_load, emit_en && (emit_cnt == cc20_pkg::LAST_CNT),
                   (step == cc20_pkg::STEP_LOAD) && (load_cnt == '0), "no return to load")
  `CC20_ASSERT_NXT(a_round_exit, (step == cc20_pkg::STEP_ROUND_END) && !rounds_left,
                   (step == cc20_pkg::STEP_EMIT) && (emit_cnt == '0), "bad round exit")
  `CC20_ASSERT_IMP(a_emit_clean, emit_en, load_cnt == '0, "emit with partial load")

endmodule

/* hw/rtl/cc20_datapath.sv */
`timescale 1ns / 1ps
// datapath: saved input words, working words, four quarter-round lanes
// and the output register; depends on cc20_pkg
module cc20_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cc20_pkg::ctrl_t               ctrl,
  input  logic [cc20_pkg::WORD_W-1:0]   state_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cc20_pkg::WORD_W-1:0]   key_word,
  output logic                          key_last
);

  logic [cc20_pkg::WORD_W-1:0] saved      [16];
  logic [cc20_pkg::WORD_W-1:0] saved_next [16];
  logic [cc20_pkg::WORD_W-1:0] work       [16];
  logic [cc20_pkg::WORD_W-1:0] work_next  [16];
  logic [cc20_pkg::WORD_W-1:0] lane_a     [4];
  logic [cc20_pkg::WORD_W-1:0] lane_c     [4];

  // rotate for the a/d half step: 16 or 8
  function automatic logic [31:0] rot_ad(input logic [31:0] x, input logic hi);
    return hi ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
  endfunction

  // rotate for the c/b half step: 12 or 7
  function automatic logic [31:0] rot_cb(input logic [31:0] x, input logic hi);
    return hi ? {x[24:0], x[31:25]} : {x[19:0], x[31:20]};
  endfunction

  // lane adders, one per column
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_a[i] = work[i] + work[4 + i];
      lane_c[i] = work[8 + i] + work[12 + i];
    end
  end

  // next values of the word registers
  always_comb begin
    saved_next = saved;
    work_next  = work;
    case (ctrl.op)
      cc20_pkg::OP_LOAD: begin
        if (ctrl.load_en) begin
          for (int i = 0; i < 15; i++) begin
            saved_next[i] = saved[i + 1];
          end
          saved_next[15] = state_word;
        end
      end
      cc20_pkg::OP_COPY: work_next = saved;
      cc20_pkg::OP_STEP_AD: begin
        for (int i = 0; i < 4; i++) begin
          work_next[i]      = lane_a[i];
          work_next[12 + i] = rot_ad(work[12 + i] ^ lane_a[i], ctrl.rot_hi);
        end
      end
      cc20_pkg::OP_STEP_CB: begin
        for (int i = 0; i < 4; i++) begin
          work_next[8 + i] = lane_c[i];
          work_next[4 + i] = rot_cb(work[4 + i] ^ lane_c[i], ctrl.rot_hi);
        end
      end
      // row r turns left by r so diagonals line up as columns
      cc20_pkg::OP_DIAG: begin
        for (int r = 1; r < 4; r++) begin
          for (int i = 0; i < 4; i++) begin
            work_next[4 * r + i] = work[4 * r + ((i + r) & 3)];
          end
        end
      end
      cc20_pkg::OP_UNDIAG: begin
        for (int r = 1; r < 4; r++) begin
          for (int i = 0; i < 4; i++) begin
            work_next[4 * r + i] = work[4 * r + ((i + 4 - r) & 3)];
          end
        end
      end
      // shift both word sets down as words leave
      cc20_pkg::OP_EMIT: begin
        if (ctrl.emit_en) begin
          for (int i = 0; i < 15; i++) begin
            work_next[i]  = work[i + 1];
            saved_next[i] = saved[i + 1];
          end
        end
      end
      default: ;
    endcase
  end

  // word registers
  always_ff @(posedge clk) begin
    saved <= saved_next;
    work  <= work_next;
  end

  // output register with final feed-forward add
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (ctrl.emit_en) begin
      key_word <= work[0] + saved[0];
      key_last <= ctrl.last;
    end
  end

endmodule

/* hw/rtl/chacha20_block_function_unit.sv */
`timescale 1ns / 1ps
// top level of the chacha20 block function unit
// depends on cc20_pkg, cc20_sequencer and cc20_datapath
// Usage:
//   Input channel (state_word, in_valid, in_stall): sixteen items per block,
//   state words 0 to 15 in order. An item is taken at a clock edge with
//   in_valid high and in_stall low; in_stall is low only while loading.
//   Output channel (key_word, key_last, out_valid, out_stall): sixteen items
//   per block, keystream words 0 to 15, key_last high on word 15.
//   Steps per block: one load step per input item, one copy step, then
//   ROUND_PAIRS round pairs (four half steps per round plus one row-turn
//   step each way, one add per lane per cycle), then one emit step per key
//   item through the single output register. One block is in work at a
//   time.
//   Reset: the sequencer returns to loading with all counters at zero and
//   the output register empty; word storage is not cleared.
//   Receiver stall: the output register holds its item, the emit step waits
//   and the input stays stalled until word 15 is in the output register.

module chacha20_block_function_unit #(
  parameter int ROUND_PAIRS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] state_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] key_word,
  output logic        key_last
);

  cc20_pkg::ctrl_t ctrl;

  // program sequencer
  cc20_sequencer #(
    .ROUND_PAIRS(ROUND_PAIRS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ctrl     (ctrl)
  );

  // word storage and lanes
  cc20_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .state_word(state_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_word  (key_word),
    .key_last  (key_last)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for chacha20_block_function_unit: feeds state words,
// predicts each keystream block and checks every key item; depends on cc20_pkg
module testbench;

  localparam int WORD_W         = cc20_pkg::WORD_W;
  localparam int ROUND_PAIRS    = 10;
  localparam int BLOCK_WORDS    = 16;
  localparam int DIRECTED_ROWS  = 32;
  localparam int RANDOM_BLOCKS  = 20;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int FIRST_KEY_LAT  = 2 + 10 * ROUND_PAIRS;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_t;
  typedef struct packed {
    word_t word;
    logic  last;
  } key_item_t;
  typedef struct packed {
    word_t word;
    logic  typed;
    word_t key;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t state_word = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t key_word;
  logic  key_last;

  chacha20_block_function_unit #(
    .ROUND_PAIRS(ROUND_PAIRS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .state_word(state_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .key_word(key_word),
    .key_last(key_last)
  );

  // directed rows: the all-zero state stays zero through every round and the
  // final add, so its keystream is zero; the second block mixes extreme words
  stim_row_t dir_table [DIRECTED_ROWS] = '{
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'h00000000, 1'b1, 32'h00000000}, '{32'h00000000, 1'b1, 32'h00000000},
    '{32'hFFFFFFFF, 1'b0, 32'h0}, '{32'h00000000, 1'b0, 32'h0},
    '{32'h00000001, 1'b0, 32'h0}, '{32'h80000000, 1'b0, 32'h0},
    '{32'h7FFFFFFF, 1'b0, 32'h0}, '{32'hFFFFFFFE, 1'b0, 32'h0},
    '{32'hAAAAAAAA, 1'b0, 32'h0}, '{32'h55555555, 1'b0, 32'h0},
    '{32'h61707865, 1'b0, 32'h0}, '{32'h3320646E, 1'b0, 32'h0},
    '{32'h79622D32, 1'b0, 32'h0}, '{32'h6B206574, 1'b0, 32'h0},
    '{32'h00000001, 1'b0, 32'h0}, '{32'h09000000, 1'b0, 32'h0},
    '{32'h4A000000, 1'b0, 32'hFFFFFFFF}, '{32'hFFFFFFFF, 1'b0, 32'h0}
  };

  // expected keystream items, oldest first
  key_item_t pending_keys [$];

  // words of the block being loaded, as seen on accepted items
  block_t            loaded_words;
  block_t            typed_keys;
  logic [15:0]       typed_flags;
  int                load_idx = 0;
  int                words_sent = 0;
  int                blocks_sent = 0;
  int                keys_checked = 0;
  int                errors = 0;
  int                quiet_cycles = 0;
  bit                snd_busy = 1'b0;
  bit                rcv_busy = 1'b0;
  bit                hold_req = 1'b0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  function automatic word_t rotl(input word_t x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic logic [4*WORD_W-1:0] quarter_round(input word_t a, input word_t b,
                                                        input word_t c, input word_t d);
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  // keystream of one input state: double rounds, then add the input back
  function automatic block_t chacha_block(input block_t init);
    block_t w;
    w = init;
    for (int r = 0; r < ROUND_PAIRS; r++) begin
      {w[0], w[4], w[8], w[12]}  = quarter_round(w[0], w[4], w[8], w[12]);
      {w[1], w[5], w[9], w[13]}  = quarter_round(w[1], w[5], w[9], w[13]);
      {w[2], w[6], w[10], w[14]} = quarter_round(w[2], w[6], w[10], w[14]);
      {w[3], w[7], w[11], w[15]} = quarter_round(w[3], w[7], w[11], w[15]);
      {w[0], w[5], w[10], w[15]} = quarter_round(w[0], w[5], w[10], w[15]);
      {w[1], w[6], w[11], w[12]} = quarter_round(w[1], w[6], w[11], w[12]);
      {w[2], w[7], w[8], w[13]}  = quarter_round(w[2], w[7], w[8], w[13]);
      {w[3], w[4], w[9], w[14]}  = quarter_round(w[3], w[4], w[9], w[14]);
    end
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      w[i] = w[i] + init[i];
    end
    return w;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (!busy || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random state with one of several shapes
  function automatic block_t random_block();
    block_t b;
    int     shape;
    shape = $urandom_range(0, 3);
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      case (shape)
        0: b[i] = $urandom;
        1: b[i] = (i < 4) ? word_t'(0) : $urandom;
        2: begin
          case ($urandom_range(0, 3))
            0: b[i] = '0;
            1: b[i] = '1;
            2: b[i] = word_t'(1) << $urandom_range(0, WORD_W - 1);
            default: b[i] = $urandom;
          endcase
        end
        default: b[i] = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      endcase
    end
    // cipher-like layout: constants, key, small counter, nonce
    if (shape == 1) begin
      b[0]  = 32'h61707865;
      b[1]  = 32'h3320646E;
      b[2]  = 32'h79622D32;
      b[3]  = 32'h6B206574;
      b[12] = $urandom_range(0, 7);
    end
    return b;
  endfunction

  // offer one item and wait until it is taken; record expectations on word 15
  task automatic send_word(input word_t w, input logic tv, input word_t tk);
    int     gap;
    block_t ks;
    gap = pick_gap(snd_busy);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    state_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    loaded_words[load_idx] = w;
    typed_flags[load_idx]  = tv;
    typed_keys[load_idx]   = tk;
    load_idx++;
    words_sent++;
    if (load_idx == BLOCK_WORDS) begin
      load_idx = 0;
      blocks_sent++;
      ks = chacha_block(loaded_words);
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        pending_keys.push_back('{typed_flags[i] ? typed_keys[i] : ks[i],
                                 i == BLOCK_WORDS - 1});
      end
    end
  endtask

  // receiver: random stall runs, plus one long hold on request
  initial begin
    int hold_left;
    int stall_run;
    hold_left = 0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (rcv_busy && $urandom_range(0, 99) < 30) stall_run = pick_gap(1'b1);
      end
    end
  end

  // key item checker
  always @(posedge clk) begin
    key_item_t want;
    if (!rst && out_valid && !out_stall) begin
      keys_checked++;
      if (pending_keys.size() == 0) begin
        $error("key item with none expected: key_word=%h key_last=%b", key_word, key_last);
        errors++;
      end else begin
        want = pending_keys.pop_front();
        if (key_word !== want.word) begin
          $error("key_word: expected %h, got %h", want.word, key_word);
          errors++;
        end
        if (key_last !== want.last) begin
          $error("key_last: expected %b, got %b", want.last, key_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item taken on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, directed table, random blocks, drain
  initial begin
    block_t rb;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // first block without idling, the second with idling on both sides
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == BLOCK_WORDS) begin
        snd_busy = 1'b1;
        rcv_busy = 1'b1;
      end
      send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].key);
    end

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      snd_busy = ($urandom_range(0, 3) != 0);
      rcv_busy = ($urandom_range(0, 3) != 0);
      // long receiver hold while the next block is offered at once
      if (blk == 4) begin
        snd_busy = 1'b0;
        hold_req = 1'b1;
      end
      // sender goes idle and waits for the previous block to drain completely
      if (blk == 9) begin
        @(negedge clk) in_valid <= 1'b0;
        wait (pending_keys.size() == 0);
      end
      rb = random_block();
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        send_word(rb[i], 1'b0, '0);
      end
    end
    @(negedge clk) in_valid <= 1'b0;

    wait (pending_keys.size() == 0);
    repeat (2 * FIRST_KEY_LAT) @(posedge clk);

    $display("covered %0d blocks from %0d state words, %0d key items checked,",
             blocks_sent, words_sent, keys_checked);
    $display("with idle gaps on both sides, one long output hold and one drained pause");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
